// ----- sv/brf_pkg.sv -----
package brf_pkg;

   // Widths fixed by the stream and register formats.
   localparam int VAL_WIDTH      = 20;
   localparam int CNT_WIDTH      = 6;
   localparam int CSR_ADDR_WIDTH = 3;
   localparam int CSR_DATA_WIDTH = 32;
   localparam int REQ_DATA_WIDTH = 40;
   localparam int RSP_DATA_WIDTH = 24;

   // Width of one slice of the running power fed to the shared multiplier.
   localparam int MUL_CHUNK = 32;

   // Reset value of the halving count.
   localparam logic [CNT_WIDTH-1:0] ITER_COUNT_RESET = 6'd7;

   // Register index, taken from paddr bit 2.
   localparam logic CSR_IDX_ITER_COUNT = 1'b0;

   // Main sequencer.
   typedef enum logic [2:0] {
      S_IDLE,
      S_EVAL_A,
      S_EVAL_B,
      S_EVAL_C,
      S_NEXT,
      S_OUT
   } seq_state_type;

   // Polynomial sign unit.
   typedef enum logic [1:0] {
      P_IDLE,
      P_MAC,
      P_NORM,
      P_SUM
   } poly_state_type;

   // Result of one evaluation, valid while done is high.
   typedef struct packed {
      logic done;
      logic positive;
      logic negative;
   } eval_status_type;

endpackage

// ----- sv/bisection_root_finder.sv -----
// Bisection root finder for f(x) = x^5 - 4x - 3 on signed fixed-point intervals.
// Each evaluation of f runs on one 32x20 multiply-accumulate unit, and a result
// follows N halvings of the interval, or none when the ends are unbracketed.
// One item at a time: the next beat is taken once the result has moved to the
// output register, so no new beat is accepted while one is in flight.
// Reset (synchronous, active high) empties the block and sets the count to 7.
module bisection_root_finder
   import brf_pkg::*;
#(
   parameter int FRAC_BITS = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   // Input stream.
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [REQ_DATA_WIDTH-1:0] req_tdata,   // [19:0] lower_end, [39:20] upper_end
   // Result stream.
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [RSP_DATA_WIDTH-1:0] rsp_tdata,   // [19:0] root_estimate, [23:20] zero
   output logic                      rsp_tuser,   // [0] bracketed
   // Register port.
   input  logic                      csr_psel,
   input  logic                      csr_penable,
   input  logic                      csr_pwrite,
   input  logic [CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  logic [CSR_DATA_WIDTH-1:0] csr_pwdata,
   output logic [CSR_DATA_WIDTH-1:0] csr_prdata,
   output logic                      csr_pready
);

   seq_state_type               state_ff, state_in;
   logic [CNT_WIDTH-1:0]        iter_count_ff, iter_count_in;
   logic signed [VAL_WIDTH-1:0] a_ff, a_in;
   logic signed [VAL_WIDTH-1:0] b_ff, b_in;
   logic                        sa_pos_ff, sa_pos_in;
   logic                        sa_neg_ff, sa_neg_in;
   logic                        bracket_ff, bracket_in;
   logic [CNT_WIDTH-1:0]        left_ff, left_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [VAL_WIDTH-1:0]        rsp_root_ff, rsp_root_in;
   logic                        rsp_brk_ff, rsp_brk_in;

   logic                        req_accept;
   logic                        out_free;
   logic                        csr_write;
   logic signed [VAL_WIDTH:0]   mid_sum;
   logic signed [VAL_WIDTH-1:0] mid;
   logic                        brk_now;
   logic                        flip;
   logic                        eval_start;
   logic signed [VAL_WIDTH-1:0] eval_x;
   eval_status_type             eval_status;

   // Register port: one register, written in the access phase.
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = (csr_paddr[2] == CSR_IDX_ITER_COUNT)
                       ? CSR_DATA_WIDTH'(iter_count_ff) : '0;

   always_comb begin
      iter_count_in = iter_count_ff;
      if (csr_write && (csr_paddr[2] == CSR_IDX_ITER_COUNT)) begin
         iter_count_in = csr_pwdata[CNT_WIDTH-1:0];
      end
   end

   // Handshake terms.
   assign req_tready = (state_ff == S_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_DATA_WIDTH'(rsp_root_ff);
   assign rsp_tuser  = rsp_brk_ff;

   // Floor midpoint of the current interval.
   assign mid_sum = {a_ff[VAL_WIDTH-1], a_ff} + {b_ff[VAL_WIDTH-1], b_ff};
   assign mid     = mid_sum[VAL_WIDTH:1];

   // Sign tests on the finished evaluation.
   assign brk_now = (sa_pos_ff && eval_status.negative) ||
                    (sa_neg_ff && eval_status.positive);
   assign flip    = sa_pos_ff ? eval_status.negative : eval_status.positive;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_accept) state_in = S_EVAL_A;
         end
         S_EVAL_A: begin
            if (eval_status.done) state_in = S_EVAL_B;
         end
         S_EVAL_B: begin
            if (eval_status.done) begin
               state_in = (brk_now && (left_ff != '0)) ? S_EVAL_C : S_OUT;
            end
         end
         S_EVAL_C: begin
            if (eval_status.done) state_in = S_NEXT;
         end
         S_NEXT: begin
            state_in = (left_ff == '0) ? S_OUT : S_EVAL_C;
         end
         S_OUT: begin
            if (out_free) state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Sequencer outputs and datapath updates.
   always_comb begin
      a_in         = a_ff;
      b_in         = b_ff;
      sa_pos_in    = sa_pos_ff;
      sa_neg_in    = sa_neg_ff;
      bracket_in   = bracket_ff;
      left_in      = left_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_root_in  = rsp_root_ff;
      rsp_brk_in   = rsp_brk_ff;
      eval_start   = 1'b0;
      eval_x       = mid;
      case (state_ff)
         S_IDLE: begin
            eval_x = req_tdata[VAL_WIDTH-1:0];
            if (req_accept) begin
               a_in       = req_tdata[VAL_WIDTH-1:0];
               b_in       = req_tdata[2*VAL_WIDTH-1:VAL_WIDTH];
               left_in    = iter_count_ff;
               eval_start = 1'b1;
            end
         end
         S_EVAL_A: begin
            eval_x = b_ff;
            if (eval_status.done) begin
               sa_pos_in  = eval_status.positive;
               sa_neg_in  = eval_status.negative;
               eval_start = 1'b1;
            end
         end
         S_EVAL_B: begin
            if (eval_status.done) begin
               bracket_in = brk_now;
               eval_start = brk_now && (left_ff != '0);
            end
         end
         S_EVAL_C: begin
            if (eval_status.done) begin
               if (flip) begin
                  b_in = mid;
               end else begin
                  a_in = mid;
               end
               left_in = left_ff - CNT_WIDTH'(1);
            end
         end
         S_NEXT: begin
            eval_start = (left_ff != '0);
         end
         S_OUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_root_in  = bracket_ff ? mid : '0;
               rsp_brk_in   = bracket_ff;
            end
         end
         default: begin
            eval_start = 1'b0;
         end
      endcase
   end

   brf_poly_sign #(
      .FRAC_BITS(FRAC_BITS)
   ) u_poly_sign (
      .clock (clock),
      .reset (reset),
      .start (eval_start),
      .x     (eval_x),
      .status(eval_status)
   );

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         iter_count_ff <= ITER_COUNT_RESET;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         iter_count_ff <= iter_count_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      a_ff        <= a_in;
      b_ff        <= b_in;
      sa_pos_ff   <= sa_pos_in;
      sa_neg_ff   <= sa_neg_in;
      bracket_ff  <= bracket_in;
      left_ff     <= left_in;
      rsp_root_ff <= rsp_root_in;
      rsp_brk_ff  <= rsp_brk_in;
   end

   // An unbracketed result always carries a zero estimate.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_brk_ff |-> rsp_root_ff == '0)
      else $error("unbracketed result with non-zero estimate");

   // The polynomial unit only finishes while the sequencer waits for it.
   assert property (@(posedge clock) disable iff (reset)
      eval_status.done |->
         (state_ff == S_EVAL_A) || (state_ff == S_EVAL_B) || (state_ff == S_EVAL_C))
      else $error("evaluation finished outside an evaluation state");

   // A sign is never both positive and negative.
   assert property (@(posedge clock) disable iff (reset)
      eval_status.done |-> !(eval_status.positive && eval_status.negative))
      else $error("evaluation reports both signs");

   // An accepted beat always starts the evaluation at the lower end.
   assert property (@(posedge clock) disable iff (reset)
      req_accept |=> state_ff == S_EVAL_A)
      else $error("accepted beat did not start an evaluation");

endmodule

// ----- sv/brf_poly_sign.sv -----
module brf_poly_sign
   import brf_pkg::*;
#(
   parameter int FRAC_BITS = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic signed [VAL_WIDTH-1:0] x,
   output eval_status_type             status
);

   // Magnitude of a saturated, shifted product, and derived widths.
   localparam int PW     = 63 - FRAC_BITS;
   localparam int NCHUNK = (PW + MUL_CHUNK - 1) / MUL_CHUNK;
   localparam int CIW    = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;
   localparam int AW     = PW + VAL_WIDTH;
   localparam int MW     = (AW > 63) ? AW : 63;
   localparam int FW     = PW + 3;
   localparam int PADW   = NCHUNK * MUL_CHUNK;
   localparam int PRODW  = MUL_CHUNK + VAL_WIDTH;
   localparam logic [CIW-1:0] TOP_CHUNK = CIW'(NCHUNK - 1);
   localparam logic [62:0]    PROD_LIMIT = 63'(1) << 62;
   localparam logic [63:0]    ROUND_ADD  = (64'(1) << FRAC_BITS) - 64'(1);
   localparam logic [1:0]     LAST_POWER = 2'd3;

   poly_state_type                 state_ff, state_in;
   logic signed [VAL_WIDTH-1:0]    x_ff, x_in;
   logic [VAL_WIDTH-1:0]           xmag_ff, xmag_in;
   logic [PW-1:0]                  pmag_ff, pmag_in;
   logic                           pneg_ff, pneg_in;
   logic [1:0]                     pow_ff, pow_in;
   logic [CIW-1:0]                 chunk_ff, chunk_in;
   logic [AW-1:0]                  acc_ff, acc_in;

   logic [PADW-1:0]                pmag_pad;
   logic [MUL_CHUNK-1:0]           chunk_val;
   logic [PRODW-1:0]               prod;
   logic [AW-1:0]                  acc_mac;
   logic [MW-1:0]                  acc_ext;
   logic [62:0]                    mclip;
   logic                           prod_neg;
   logic [63:0]                    rsum;
   logic [PW-1:0]                  pmag_norm;
   logic signed [PW:0]             x5_s;
   logic signed [FW-1:0]           x5_ext;
   logic signed [FW-1:0]           xs_ext;
   logic signed [FW-1:0]           fv;
   logic [VAL_WIDTH-1:0]           x_abs;

   // Multiply-accumulate: one slice of the power times |x|, highest slice first.
   always_comb begin
      pmag_pad  = PADW'(pmag_ff);
      chunk_val = pmag_pad[chunk_ff*MUL_CHUNK +: MUL_CHUNK];
      prod      = PRODW'(chunk_val) * PRODW'(xmag_ff);
      acc_mac   = (acc_ff << MUL_CHUNK) + AW'(prod);
   end

   // Saturate the magnitude, then shift with rounding toward minus infinity.
   always_comb begin
      acc_ext   = MW'(acc_ff);
      mclip     = (acc_ext > MW'(PROD_LIMIT)) ? PROD_LIMIT : acc_ext[62:0];
      prod_neg  = pneg_ff ^ x_ff[VAL_WIDTH-1];
      rsum      = {1'b0, mclip} + (prod_neg ? ROUND_ADD : 64'(0));
      pmag_norm = rsum[FRAC_BITS +: PW];
   end

   // Final sum f = x^5 - 4x - 3, of which only the sign is kept.
   always_comb begin
      x5_s   = pneg_ff ? -$signed({1'b0, pmag_ff}) : $signed({1'b0, pmag_ff});
      x5_ext = {{(FW-PW-1){x5_s[PW]}}, x5_s};
      xs_ext = {{(FW-VAL_WIDTH){x_ff[VAL_WIDTH-1]}}, x_ff};
      fv     = x5_ext - (xs_ext <<< 2) - (FW'(3) << FRAC_BITS);
   end

   assign x_abs = x[VAL_WIDTH-1] ? VAL_WIDTH'(-x) : VAL_WIDTH'(x);

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         P_IDLE: begin
            if (start) state_in = P_MAC;
         end
         P_MAC: begin
            if (chunk_ff == '0) state_in = P_NORM;
         end
         P_NORM: begin
            state_in = (pow_ff == LAST_POWER) ? P_SUM : P_MAC;
         end
         P_SUM: begin
            state_in = start ? P_MAC : P_IDLE;
         end
         default: begin
            state_in = P_IDLE;
         end
      endcase
   end

   // Datapath control and status.
   always_comb begin
      x_in     = x_ff;
      xmag_in  = xmag_ff;
      pmag_in  = pmag_ff;
      pneg_in  = pneg_ff;
      pow_in   = pow_ff;
      chunk_in = chunk_ff;
      acc_in   = acc_ff;
      status   = '0;
      case (state_ff)
         P_IDLE: begin
            if (start) begin
               x_in     = x;
               xmag_in  = x_abs;
               pmag_in  = PW'(x_abs);
               pneg_in  = x[VAL_WIDTH-1];
               pow_in   = '0;
               chunk_in = TOP_CHUNK;
               acc_in   = '0;
            end
         end
         P_MAC: begin
            acc_in   = acc_mac;
            chunk_in = chunk_ff - CIW'(1);
         end
         P_NORM: begin
            pmag_in  = pmag_norm;
            pneg_in  = prod_neg;
            pow_in   = pow_ff + 2'd1;
            chunk_in = TOP_CHUNK;
            acc_in   = '0;
         end
         P_SUM: begin
            status.done     = 1'b1;
            status.negative = fv[FW-1];
            status.positive = !fv[FW-1] && (fv != '0);
            // The next evaluation may start in the cycle that reports this sign.
            if (start) begin
               x_in     = x;
               xmag_in  = x_abs;
               pmag_in  = PW'(x_abs);
               pneg_in  = x[VAL_WIDTH-1];
               pow_in   = '0;
               chunk_in = TOP_CHUNK;
               acc_in   = '0;
            end
         end
         default: begin
            status = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= P_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff     <= x_in;
      xmag_ff  <= xmag_in;
      pmag_ff  <= pmag_in;
      pneg_ff  <= pneg_in;
      pow_ff   <= pow_in;
      chunk_ff <= chunk_in;
      acc_ff   <= acc_in;
   end

endmodule
